// File: sv/fat16sm_pkg.sv
// ----------------------------------------------------------------------------
// FAT16 sector mapper package
// Operation codes, register indexes and field widths shared by the mapper.
// ----------------------------------------------------------------------------
package fat16sm_pkg;

    // Field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned CLUSTER_W = 16;
    localparam int unsigned LBA_W     = 32;
    localparam int unsigned SPC_W     = 8;
    localparam int unsigned OFFSET_W  = 9;
    localparam int unsigned CFG_IDX_W = 2;

    // Operation carried in s_tuser
    typedef enum logic [OP_W-1:0] {
        OP_OPEN    = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_LINK    = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    // Result kind carried in m_tuser
    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_FAT  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAT_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPC        = 2'd2;

    // Reset value of the cluster size register
    localparam logic [SPC_W-1:0] SPC_RESET = 8'd1;

endpackage

// File: sv/fat16_file_sector_mapper.sv
// ----------------------------------------------------------------------------
// FAT16 file sector mapper
// Tracks a file cursor (cluster, sector in cluster) and maps it to sector
// addresses, asking for the FAT entry whenever a cluster boundary is crossed.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one command item per handshake: the operation in
//   s_tuser (open, advance, link, query) and a cluster word in s_tdata.
//   Every command item yields exactly one result item on the m_ channel:
//   m_tuser gives the kind (data sector or FAT fetch request) and m_tdata
//   gives the sector address and, for a FAT request, the entry byte offset.
//   The cfg_ channel writes the FAT start, data start and cluster size
//   registers; it is always ready. It is to be used only while the block is
//   idle; the block itself does not enforce this. An accepted item waits in
//   the input register and goes through the cursor update and the
//   9 x 17 bit address multiply into the result register, which drives
//   m_tvalid. One item is accepted every cycle while the receiver does not
//   stall.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item; s_tready then drops until the
//   result is taken. Reset clears both stages, the cursor and the registers
//   (cluster size returns to one sector).
// ----------------------------------------------------------------------------
module fat16_file_sector_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Command channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fat16sm_pkg::CLUSTER_W-1:0]   s_tdata,  // [15:0] cluster_value
    input  logic [fat16sm_pkg::OP_W-1:0]        s_tuser,  // [1:0] operation
    // Result channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,  // [31:0] sector_lba,
                                                          // [40:32] fat_entry_offset,
                                                          // [47:41] zero
    output logic                                m_tuser,  // [0] result_kind
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fat16sm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fat16sm_pkg::LBA_W-1:0]       cfg_data
);
    import fat16sm_pkg::*;

    // Configuration registers
    logic [LBA_W-1:0]     fat_start_reg;
    logic [LBA_W-1:0]     data_start_reg;
    logic [SPC_W-1:0]     spc_reg;

    // Cursor state
    logic [CLUSTER_W-1:0] cluster_reg;
    logic [CLUSTER_W-1:0] cluster_next;
    logic [SPC_W-1:0]     sector_reg;
    logic [SPC_W-1:0]     sector_next;

    // Input stage
    logic                 in_valid_reg;
    op_t                  in_op_reg;
    logic [CLUSTER_W-1:0] in_value_reg;

    // Result stage
    logic                 out_valid_reg;
    logic                 out_kind_reg;
    logic [LBA_W-1:0]     out_lba_reg;
    logic [OFFSET_W-1:0]  out_offset_reg;

    // Datapath
    logic                 out_load;
    logic                 process;
    logic [SPC_W:0]       span;
    logic [SPC_W:0]       sector_inc;
    logic                 crossing;
    logic                 kind_next;
    logic signed [CLUSTER_W:0]         cluster_rel;
    logic signed [CLUSTER_W+SPC_W+2:0] cluster_base;
    logic [LBA_W-1:0]     data_lba;
    logic [LBA_W-1:0]     fat_lba;
    logic [LBA_W-1:0]     lba_next;
    logic [OFFSET_W-1:0]  offset_next;

    // Handshakes: the result register frees when empty or taken
    assign out_load  = !out_valid_reg || m_tready;
    assign process   = in_valid_reg && out_load;
    assign s_tready  = !in_valid_reg || out_load;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {7'd0, out_offset_reg, out_lba_reg};

    // A cluster size of zero stands for 256 sectors
    assign span       = {(spc_reg == '0), spc_reg};
    assign sector_inc = {1'b0, sector_reg} + 9'd1;
    assign crossing   = (sector_inc >= span);

    // Cursor update for the item in the input register
    always_comb begin
        cluster_next = cluster_reg;
        sector_next  = sector_reg;
        kind_next    = KIND_DATA;
        case (in_op_reg)
            OP_OPEN: begin
                cluster_next = in_value_reg;
                sector_next  = '0;
            end
            OP_ADVANCE: begin
                if (crossing) begin
                    sector_next = '0;
                    kind_next   = KIND_FAT;
                end else begin
                    sector_next = sector_inc[SPC_W-1:0];
                end
            end
            OP_LINK: begin
                cluster_next = in_value_reg;
            end
            default: begin
            end
        endcase
    end

    // Data address from the updated cursor; cluster - 2 may go negative
    assign cluster_rel  = $signed({1'b0, cluster_next}) - 17'sd2;
    assign cluster_base = cluster_rel * $signed({1'b0, span});
    assign data_lba     = data_start_reg
                        + {{(LBA_W-(CLUSTER_W+SPC_W+3)){cluster_base[CLUSTER_W+SPC_W+2]}},
                           cluster_base}
                        + {{(LBA_W-SPC_W){1'b0}}, sector_next};

    // FAT sector and entry offset for the current cluster
    assign fat_lba = fat_start_reg + {{(LBA_W-8){1'b0}}, cluster_reg[CLUSTER_W-1:8]};

    assign lba_next    = (kind_next == KIND_FAT) ? fat_lba : data_lba;
    assign offset_next = (kind_next == KIND_FAT) ? {cluster_reg[7:0], 1'b0} : '0;

    // Control state, configuration and cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            cluster_reg    <= '0;
            sector_reg     <= '0;
            fat_start_reg  <= '0;
            data_start_reg <= '0;
            spc_reg        <= SPC_RESET;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                cluster_reg <= cluster_next;
                sector_reg  <= sector_next;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FAT_START:  fat_start_reg  <= cfg_data;
                    REG_DATA_START: data_start_reg <= cfg_data;
                    REG_SPC:        spc_reg        <= cfg_data[SPC_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= op_t'(s_tuser);
            in_value_reg <= s_tdata;
        end
        if (process) begin
            out_kind_reg   <= kind_next;
            out_lba_reg    <= lba_next;
            out_offset_reg <= offset_next;
        end
    end

    // A FAT request always points at an even byte offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_FAT) |-> (m_tdata[32] == 1'b0))
        else $error("FAT request with odd entry offset");

    // A data result carries no entry offset
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[40:32] == '0))
        else $error("data result with nonzero entry offset");

    // Crossing a cluster boundary returns the position to the start
    assert property (@(posedge aclk) disable iff (!aresetn)
        process && (in_op_reg == OP_ADVANCE) && crossing |=> (sector_reg == '0))
        else $error("position not cleared at cluster boundary");

    // Open loads the cluster word and clears the position
    assert property (@(posedge aclk) disable iff (!aresetn)
        process && (in_op_reg == OP_OPEN)
        |=> (cluster_reg == $past(in_value_reg)) && (sector_reg == '0))
        else $error("open did not load the cursor");

    // Every processed item produces a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> out_valid_reg)
        else $error("processed item did not reach the result register");

endmodule
